FILE: design/fir_pkg.sv
// Shared types and constants for the primed FIR filter.
// Depends on nothing; every other design file imports it.
package fir_pkg;

   localparam int TAPS       = 8;
   localparam int NCOEF      = 8;
   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 16;
   localparam int FRAC_W     = 14;
   localparam int PTR_W      = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int COEF_IDX_W = $clog2(NCOEF);
   localparam int PROD_W     = SAMPLE_W + COEF_W;
   localparam int ACC_W      = PROD_W + COEF_IDX_W;
   localparam int SHIFTED_W  = ACC_W - FRAC_W;
   localparam int ADDR_W     = COEF_IDX_W + 2;
   localparam int DATA_W     = 32;

   typedef logic signed [COEF_W-1:0] coef_type;
   typedef coef_type [NCOEF-1:0] coef_bank_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       prime;
   } req_item_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] filtered;
      logic                       clipped;
   } rsp_item_type;

endpackage

FILE: design/fir_front.sv
// Input side: a two-entry queue that takes samples and marks those that prime the delay line.
// Depends on fir_pkg.
module fir_front import fir_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   output logic                       full,
   input  logic signed [SAMPLE_W-1:0] sample_in,
   input  logic                       restart,
   output logic                       item_empty,
   output req_item_type               item,
   input  logic                       item_pop
);

   req_item_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       seen_ff, seen_in;
   logic       do_push, do_pop;
   req_item_type new_item;

   assign full       = (count_ff == 2'd2);
   assign item_empty = (count_ff == 2'd0);
   assign do_push    = push && !full;
   assign do_pop     = item_pop && !item_empty;
   assign item       = entry_ff[rd_ptr_ff];

   always_comb begin
      new_item.sample = sample_in;
      new_item.prime  = restart || !seen_ff;
      wr_ptr_in       = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in       = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      seen_in         = seen_ff || do_push;
      count_in        = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
         seen_ff   <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         seen_ff   <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

FILE: design/fir_back.sv
// Filter engine: delay line, write pointer and one shared multiply-accumulate unit.
// Depends on fir_pkg.
module fir_back import fir_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  coef_bank_type coef,
   input  logic          item_empty,
   input  req_item_type  item,
   output logic          item_pop,
   input  logic          rsp_full,
   output logic          rsp_push,
   output rsp_item_type  rsp_item
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_MAC   = 4'b0010,
      S_DRAIN = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic signed [SAMPLE_W-1:0] line_ff [TAPS];
   logic [PTR_W-1:0]  wp_ff, wp_in;
   logic [PTR_W-1:0]  rp_ff, rp_in;
   logic [PTR_W-1:0]  k_ff, k_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic              pvld_ff, pvld_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [SHIFTED_W-1:0] shifted;
   logic              over, under;

   assign item_pop = (state_ff == S_IDLE) && !item_empty;
   assign rsp_push = (state_ff == S_DONE) && !rsp_full;

   always_comb begin
      shifted = SHIFTED_W'(acc_ff >>> FRAC_W);
      over    = (shifted > SHIFTED_W'(32767));
      under   = (shifted < -SHIFTED_W'(32768));
      rsp_item.clipped = over || under;
      if (over) begin
         rsp_item.filtered = 16'sh7FFF;
      end else if (under) begin
         rsp_item.filtered = 16'sh8000;
      end else begin
         rsp_item.filtered = shifted[SAMPLE_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      wp_in    = wp_ff;
      rp_in    = rp_ff;
      k_in     = k_ff;
      prod_in  = prod_ff;
      pvld_in  = pvld_ff;
      acc_in   = acc_ff;
      case (state_ff)
         S_IDLE: begin
            if (!item_empty) begin
               rp_in    = wp_ff;
               wp_in    = (wp_ff == PTR_W'(TAPS - 1)) ? '0 : wp_ff + PTR_W'(1);
               k_in     = '0;
               pvld_in  = 1'b0;
               acc_in   = '0;
               state_in = S_MAC;
            end
         end
         S_MAC: begin
            prod_in = coef[COEF_IDX_W'(k_ff)] * line_ff[rp_ff];
            pvld_in = 1'b1;
            if (pvld_ff) begin
               acc_in = acc_ff + ACC_W'(prod_ff);
            end
            rp_in = (rp_ff == '0) ? PTR_W'(TAPS - 1) : rp_ff - PTR_W'(1);
            k_in  = k_ff + PTR_W'(1);
            if (k_ff == PTR_W'(TAPS - 1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            acc_in   = acc_ff + ACC_W'(prod_ff);
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_full) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         wp_ff    <= '0;
         pvld_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         wp_ff    <= wp_in;
         pvld_ff  <= pvld_in;
      end
   end

   always_ff @(posedge clock) begin
      rp_ff   <= rp_in;
      k_ff    <= k_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < TAPS; i++) begin
         if (item_pop && (item.prime || (wp_ff == PTR_W'(i)))) begin
            line_ff[i] <= item.sample;
         end
      end
   end

endmodule

FILE: design/fir_rsp_queue.sv
// Result side: a two-entry queue that holds finished results until they are taken.
// Depends on fir_pkg.
module fir_rsp_queue import fir_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  rsp_item_type push_item,
   output logic         empty,
   output rsp_item_type pop_item,
   input  logic         pop
);

   rsp_item_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: design/fir_filter_primed_delay_line.sv
// Top level of the primed FIR filter: coefficient registers and the three parts below.
// Depends on fir_pkg, fir_front, fir_back and fir_rsp_queue.
//
//   Channel   Ports                                   Transfer when
//   input     push, full, req_sample_in, req_restart  push && !full
//   result    pop, empty, rsp_filtered, rsp_clipped   pop && !empty
//   config    psel, penable, pwrite, paddr, pwdata    psel && penable && pwrite
//
// Each sample passes through the engine in order: the delay line is loaded, each tap goes
// in turn through the single shared multiplier, the product register is drained and the
// result is handed over once the result queue has room. Synchronous reset clears control
// state and the coefficient registers only; no clearing pass is needed. Two-entry queues
// on both sides let the input and result channels stall independently of the engine.
module fir_filter_primed_delay_line import fir_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   output logic                       full,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   input  logic                       req_restart,
   output logic                       empty,
   input  logic                       pop,
   output logic signed [SAMPLE_W-1:0] rsp_filtered,
   output logic                       rsp_clipped,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [ADDR_W-1:0]          paddr,
   input  logic [DATA_W-1:0]          pwdata,
   output logic [DATA_W-1:0]          prdata,
   output logic                       pready
);

   coef_bank_type coef_ff;
   logic [COEF_IDX_W-1:0] reg_idx;
   logic          csr_write;
   logic          item_empty, item_pop;
   req_item_type  item;
   logic          rsp_full, rsp_push;
   rsp_item_type  rsp_item, rsp_head;

   assign pready    = 1'b1;
   assign reg_idx   = paddr[ADDR_W-1:2];
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = DATA_W'(coef_ff[reg_idx]);

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else if (csr_write) begin
         coef_ff[reg_idx] <= pwdata[COEF_W-1:0];
      end
   end

   fir_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .sample_in  (req_sample_in),
      .restart    (req_restart),
      .item_empty (item_empty),
      .item       (item),
      .item_pop   (item_pop)
   );

   fir_back u_back (
      .clock      (clock),
      .reset      (reset),
      .coef       (coef_ff),
      .item_empty (item_empty),
      .item       (item),
      .item_pop   (item_pop),
      .rsp_full   (rsp_full),
      .rsp_push   (rsp_push),
      .rsp_item   (rsp_item)
   );

   fir_rsp_queue u_rsp (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .full      (rsp_full),
      .push_item (rsp_item),
      .empty     (empty),
      .pop_item  (rsp_head),
      .pop       (pop)
   );

   assign rsp_filtered = rsp_head.filtered;
   assign rsp_clipped  = rsp_head.clipped;

endmodule

FILE: design/fir_checker.sv
// Port-level checks for the primed FIR filter and the bind that attaches them.
// Depends on fir_pkg and fir_filter_primed_delay_line.
module fir_checker import fir_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       push,
   input logic                       full,
   input logic                       empty,
   input logic                       pop,
   input logic signed [SAMPLE_W-1:0] rsp_filtered,
   input logic                       rsp_clipped,
   input logic                       pready
);

   logic [2:0] pending_ff, pending_in;
   logic       in_xfer, out_xfer;

   assign in_xfer  = push && !full;
   assign out_xfer = pop && !empty;

   always_comb begin
      pending_in = pending_ff;
      if (in_xfer && !out_xfer) begin
         pending_in = pending_ff + 3'd1;
      end else if (out_xfer && !in_xfer) begin
         pending_in = pending_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 3'd0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_empty_after_reset: assert property (@(posedge clock) reset |=> empty)
      else $error("result queue not empty after reset");

   a_no_result_without_sample: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (pending_ff != 3'd0))
      else $error("result shown with no sample outstanding");

   a_clip_at_limit: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_clipped) |->
         (rsp_filtered == 16'sh7FFF) || (rsp_filtered == 16'sh8000))
      else $error("clipped result not at a saturation limit");

   a_pready_high: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready low");

endmodule

bind fir_filter_primed_delay_line fir_checker u_fir_checker (
   .clock        (clock),
   .reset        (reset),
   .push         (push),
   .full         (full),
   .empty        (empty),
   .pop          (pop),
   .rsp_filtered (rsp_filtered),
   .rsp_clipped  (rsp_clipped),
   .pready       (pready)
);
